// ----- rtl/core/itp_pkg.sv -----
package itp_pkg;

   // default stack depth
   localparam int STACK_DEPTH_DEFAULT = 32;

   // field widths
   localparam int CMD_W    = 3;
   localparam int CODE_W   = 3;
   localparam int HANDLE_W = 16;
   localparam int KIND_W   = 2;

   // token kinds on the request side
   localparam logic [CMD_W-1:0] CMD_NUMBER   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_OPEN     = 3'd1;
   localparam logic [CMD_W-1:0] CMD_CLOSE    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_OPERATOR = 3'd3;
   localparam logic [CMD_W-1:0] CMD_END      = 3'd4;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_NUMBER   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_OPERATOR = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PAREN    = 2'd2;
   localparam logic [KIND_W-1:0] KIND_END      = 2'd3;

   // stack entry codes
   localparam logic [CODE_W-1:0] CODE_PAREN  = 3'd0;
   localparam logic [CODE_W-1:0] CODE_OP_MIN = 3'd2;

   // precedence levels
   localparam logic [1:0] PRIO_NONE = 2'd0;
   localparam logic [1:0] PRIO_LOW  = 2'd1;
   localparam logic [1:0] PRIO_HIGH = 2'd2;

   // microcode step addresses
   typedef enum logic [3:0] {
      STEP_FETCH,
      STEP_NUM,
      STEP_PTEST,
      STEP_PEVAL,
      STEP_PUSH,
      STEP_CTEST,
      STEP_CEVAL,
      STEP_CFIN,
      STEP_ETEST,
      STEP_EPOP,
      STEP_EMARK
   } step_type;

   // micro-operations
   typedef enum logic [3:0] {
      UOP_FETCH,
      UOP_EMIT_NUM,
      UOP_READ,
      UOP_PUSH_EVAL,
      UOP_PUSH,
      UOP_CLOSE_EVAL,
      UOP_CLOSE_FIN,
      UOP_END_POP,
      UOP_END_MARK
   } uop_type;

   // control word: operation, fall-through step, conditional jump target
   typedef struct packed {
      uop_type  uop;
      step_type next;
      step_type alt;
   } ucode_word_type;

   // precedence of a stack or token code
   function automatic logic [1:0] prio_of(input logic [CODE_W-1:0] code);
      logic [1:0] p;
      case (code)
         3'd2, 3'd3:       p = PRIO_HIGH;
         3'd4, 3'd5, 3'd6: p = PRIO_LOW;
         default:          p = PRIO_NONE;
      endcase
      return p;
   endfunction

   // control program
   function automatic ucode_word_type ucode_rom(input step_type step);
      ucode_word_type w;
      case (step)
         STEP_FETCH: w = '{UOP_FETCH,      STEP_FETCH, STEP_FETCH};
         STEP_NUM:   w = '{UOP_EMIT_NUM,   STEP_FETCH, STEP_FETCH};
         STEP_PTEST: w = '{UOP_READ,       STEP_PEVAL, STEP_PUSH};
         STEP_PEVAL: w = '{UOP_PUSH_EVAL,  STEP_PTEST, STEP_PUSH};
         STEP_PUSH:  w = '{UOP_PUSH,       STEP_FETCH, STEP_FETCH};
         STEP_CTEST: w = '{UOP_READ,       STEP_CEVAL, STEP_CFIN};
         STEP_CEVAL: w = '{UOP_CLOSE_EVAL, STEP_CTEST, STEP_CFIN};
         STEP_CFIN:  w = '{UOP_CLOSE_FIN,  STEP_FETCH, STEP_FETCH};
         STEP_ETEST: w = '{UOP_READ,       STEP_EPOP,  STEP_EMARK};
         STEP_EPOP:  w = '{UOP_END_POP,    STEP_ETEST, STEP_ETEST};
         STEP_EMARK: w = '{UOP_END_MARK,   STEP_FETCH, STEP_FETCH};
         default:    w = '{UOP_FETCH,      STEP_FETCH, STEP_FETCH};
      endcase
      return w;
   endfunction

endpackage

// ----- rtl/core/infix_to_postfix_converter_unit.sv -----
// Infix to postfix token converter (shunting yard).
// Request channel: one token per item; req_tuser carries the token kind,
// req_tdata the number handle, its sign and the operator code.
// Response channel: one item per emitted postfix token, rsp_tlast on the
// final item caused by a request; an end token always closes with an end
// marker, and tokens that only push or discard produce no items.
// Timing: a sequencer steps through a small control program, one step per
// cycle while no emit waits on a stalled receiver. A number takes a fetch
// and an emit step, an ignored token only the fetch. An open paren or an
// operator ends in a push step, a close paren in a finish step and an end
// token in an end marker step, after their pops. Each popped entry costs
// one stack memory read step and one evaluate or emit step.
// The next request is accepted once the program returns to its fetch step.
// Reset (synchronous, active high) empties the stack, clears the error flag
// and drops any undelivered response. A stalled receiver holds the response
// register; the sequencer waits at the step that needs to emit, adding the
// stall cycles to the item.
module infix_to_postfix_converter_unit #(
   parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // number_handle[15:0], number_negative[16], operator_code[19:17]
   input  logic [2:0]  req_tuser,  // command[2:0]
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // out_handle[15:0], out_negative[16], out_operator[19:17], error[20]
   output logic [1:0]  rsp_tuser,  // out_kind[1:0]
   output logic        rsp_tlast
);

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W = $clog2(STACK_DEPTH);
   localparam int CODE_W = itp_pkg::CODE_W;

   // request fields
   logic [itp_pkg::CMD_W-1:0]    req_cmd;
   logic [itp_pkg::HANDLE_W-1:0] req_handle;
   logic                         req_neg;
   logic [CODE_W-1:0]            req_opc;

   assign req_cmd    = req_tuser;
   assign req_handle = req_tdata[15:0];
   assign req_neg    = req_tdata[16];
   assign req_opc    = req_tdata[19:17];

   // sequencer and datapath registers
   itp_pkg::step_type            step_ff, step_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [CNT_W-1:0]             paren_cnt_ff, paren_cnt_in;
   logic                         err_ff, err_in;
   logic                         hold_valid_ff, hold_valid_in;
   logic [CODE_W-1:0]            hold_op_ff, hold_op_in;
   logic [CODE_W-1:0]            code_ff, code_in;
   logic [itp_pkg::HANDLE_W-1:0] handle_ff, handle_in;
   logic                         neg_ff, neg_in;
   logic [CODE_W-1:0]            rd_data_ff;

   // response register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [itp_pkg::KIND_W-1:0]   rsp_kind_ff, rsp_kind_in;
   logic [itp_pkg::HANDLE_W-1:0] rsp_handle_ff, rsp_handle_in;
   logic                         rsp_neg_ff, rsp_neg_in;
   logic [CODE_W-1:0]            rsp_op_ff, rsp_op_in;
   logic                         rsp_err_ff, rsp_err_in;
   logic                         rsp_last_ff, rsp_last_in;

   // stack memory
   logic [CODE_W-1:0]            stack_mem [STACK_DEPTH];
   logic                         mem_we;
   logic                         rd_en;
   logic [CNT_W-1:0]             cnt_dec;
   logic [IDX_W-1:0]             rd_idx;
   logic [IDX_W-1:0]             wr_idx;

   // control word and emit request
   itp_pkg::ucode_word_type      word;
   logic                         emit_req;
   logic                         emit_fire;
   logic                         go;
   logic                         slot_free;
   logic [itp_pkg::KIND_W-1:0]   emit_kind;
   logic [itp_pkg::HANDLE_W-1:0] emit_handle;
   logic                         emit_neg;
   logic [CODE_W-1:0]            emit_op;
   logic                         emit_last;
   logic                         top_paren;
   logic                         top_stops;

   assign cnt_dec   = count_ff - CNT_W'(1);
   assign rd_idx    = cnt_dec[IDX_W-1:0];
   assign wr_idx    = count_ff[IDX_W-1:0];
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign go        = !emit_req || slot_free;
   assign emit_fire = emit_req && slot_free;
   assign top_paren = (rd_data_ff == itp_pkg::CODE_PAREN);
   assign top_stops = top_paren ||
                      (itp_pkg::prio_of(code_ff) < itp_pkg::prio_of(rd_data_ff));

   // sequencer: decode control word, next step and datapath updates
   always_comb begin
      word          = itp_pkg::ucode_rom(step_ff);
      step_in       = step_ff;
      count_in      = count_ff;
      paren_cnt_in  = paren_cnt_ff;
      err_in        = err_ff;
      hold_valid_in = hold_valid_ff;
      hold_op_in    = hold_op_ff;
      code_in       = code_ff;
      handle_in     = handle_ff;
      neg_in        = neg_ff;
      req_tready    = 1'b0;
      mem_we        = 1'b0;
      rd_en         = 1'b0;
      emit_req      = 1'b0;
      emit_kind     = itp_pkg::KIND_OPERATOR;
      emit_handle   = '0;
      emit_neg      = 1'b0;
      emit_op       = '0;
      emit_last     = 1'b0;

      case (word.uop)
         itp_pkg::UOP_FETCH: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               handle_in = req_handle;
               neg_in    = req_neg;
               code_in   = (req_cmd == itp_pkg::CMD_OPEN) ? itp_pkg::CODE_PAREN : req_opc;
               // an unmatched close is known up front, so its pops carry the flag
               if (req_cmd == itp_pkg::CMD_CLOSE && paren_cnt_ff == '0) begin
                  err_in = 1'b1;
               end
               case (req_cmd)
                  itp_pkg::CMD_NUMBER: step_in = itp_pkg::STEP_NUM;
                  itp_pkg::CMD_OPEN:   step_in = itp_pkg::STEP_PTEST;
                  itp_pkg::CMD_CLOSE:  step_in = itp_pkg::STEP_CTEST;
                  itp_pkg::CMD_OPERATOR: begin
                     step_in = (req_opc >= itp_pkg::CODE_OP_MIN) ?
                               itp_pkg::STEP_PTEST : itp_pkg::STEP_FETCH;
                  end
                  itp_pkg::CMD_END:    step_in = itp_pkg::STEP_ETEST;
                  default:             step_in = itp_pkg::STEP_FETCH;
               endcase
            end
         end
         itp_pkg::UOP_EMIT_NUM: begin
            emit_req    = 1'b1;
            emit_kind   = itp_pkg::KIND_NUMBER;
            emit_handle = handle_ff;
            emit_neg    = neg_ff;
            emit_last   = 1'b1;
            if (go) begin
               step_in = word.next;
            end
         end
         itp_pkg::UOP_READ: begin
            if (count_ff == '0) begin
               step_in = word.alt;
            end else begin
               rd_en   = 1'b1;
               step_in = word.next;
            end
         end
         itp_pkg::UOP_PUSH_EVAL: begin
            if (top_stops) begin
               step_in = word.alt;
            end else begin
               // previous pop goes out, this one waits to learn if it is last
               emit_req = hold_valid_ff;
               emit_op  = hold_op_ff;
               if (go) begin
                  hold_valid_in = 1'b1;
                  hold_op_in    = rd_data_ff;
                  count_in      = cnt_dec;
                  step_in       = word.next;
               end
            end
         end
         itp_pkg::UOP_PUSH: begin
            emit_req  = hold_valid_ff;
            emit_op   = hold_op_ff;
            emit_last = 1'b1;
            if (go) begin
               hold_valid_in = 1'b0;
               step_in       = word.next;
               if (count_ff >= CNT_W'(STACK_DEPTH)) begin
                  err_in = 1'b1;
               end else begin
                  mem_we   = 1'b1;
                  count_in = count_ff + CNT_W'(1);
                  if (code_ff == itp_pkg::CODE_PAREN) begin
                     paren_cnt_in = paren_cnt_ff + CNT_W'(1);
                  end
               end
            end
         end
         itp_pkg::UOP_CLOSE_EVAL: begin
            if (top_paren) begin
               count_in     = cnt_dec;
               paren_cnt_in = paren_cnt_ff - CNT_W'(1);
               step_in      = word.alt;
            end else begin
               emit_req = hold_valid_ff;
               emit_op  = hold_op_ff;
               if (go) begin
                  hold_valid_in = 1'b1;
                  hold_op_in    = rd_data_ff;
                  count_in      = cnt_dec;
                  step_in       = word.next;
               end
            end
         end
         itp_pkg::UOP_CLOSE_FIN: begin
            emit_req  = hold_valid_ff;
            emit_op   = hold_op_ff;
            emit_last = 1'b1;
            if (go) begin
               hold_valid_in = 1'b0;
               step_in       = word.next;
            end
         end
         itp_pkg::UOP_END_POP: begin
            emit_req  = 1'b1;
            emit_kind = top_paren ? itp_pkg::KIND_PAREN : itp_pkg::KIND_OPERATOR;
            emit_op   = top_paren ? '0 : rd_data_ff;
            if (go) begin
               count_in = cnt_dec;
               if (top_paren) begin
                  paren_cnt_in = paren_cnt_ff - CNT_W'(1);
               end
               step_in  = word.next;
            end
         end
         itp_pkg::UOP_END_MARK: begin
            emit_req  = 1'b1;
            emit_kind = itp_pkg::KIND_END;
            emit_last = 1'b1;
            if (go) begin
               count_in     = '0;
               paren_cnt_in = '0;
               err_in       = 1'b0;
               step_in      = word.next;
            end
         end
         default: begin
            step_in = itp_pkg::STEP_FETCH;
         end
      endcase
   end

   // response register next values
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_neg_in    = rsp_neg_ff;
      rsp_op_in     = rsp_op_ff;
      rsp_err_in    = rsp_err_ff;
      rsp_last_in   = rsp_last_ff;
      if (emit_fire) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = emit_kind;
         rsp_handle_in = emit_handle;
         rsp_neg_in    = emit_neg;
         rsp_op_in     = emit_op;
         rsp_err_in    = err_ff;
         rsp_last_in   = emit_last;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= itp_pkg::STEP_FETCH;
         count_ff      <= '0;
         paren_cnt_ff  <= '0;
         err_ff        <= 1'b0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         step_ff       <= step_in;
         count_ff      <= count_in;
         paren_cnt_ff  <= paren_cnt_in;
         err_ff        <= err_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      hold_op_ff    <= hold_op_in;
      code_ff       <= code_in;
      handle_ff     <= handle_in;
      neg_ff        <= neg_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_neg_ff    <= rsp_neg_in;
      rsp_op_ff     <= rsp_op_in;
      rsp_err_ff    <= rsp_err_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // stack memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[wr_idx] <= code_ff;
      end
      if (rd_en) begin
         rd_data_ff <= stack_mem[rd_idx];
      end
   end

   // outputs
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_err_ff, rsp_op_ff, rsp_neg_ff, rsp_handle_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_paren_bound: assert property (@(posedge clock) disable iff (reset)
      paren_cnt_ff <= count_ff)
      else $error("open paren count exceeds stack count");

   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      step_ff == itp_pkg::STEP_FETCH |-> !hold_valid_ff)
      else $error("pending pop left over at fetch");

   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == itp_pkg::KIND_END |-> rsp_last_ff)
      else $error("end marker not marked last");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      emit_fire && step_ff == itp_pkg::STEP_EMARK |=> count_ff == '0 && !err_ff)
      else $error("end marker did not clear the stack");

endmodule

// ----- dv/infix_to_postfix_converter_unit_test.sv -----
module infix_to_postfix_converter_unit_test;

   localparam int STACK_DEPTH   = itp_pkg::STACK_DEPTH_DEFAULT;
   localparam int TOTAL_TOKENS  = 460;
   localparam int CALM_TOKENS   = 40;
   localparam int HOLD_AFTER    = 150;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_CYCLES  = 100;
   localparam int CYCLE_LIMIT   = 2000000;

   localparam int CMD_W    = itp_pkg::CMD_W;
   localparam int CODE_W   = itp_pkg::CODE_W;
   localparam int HANDLE_W = itp_pkg::HANDLE_W;
   localparam int KIND_W   = itp_pkg::KIND_W;

   // operator codes by precedence class
   localparam logic [CODE_W-1:0] OP_HIGH_A   = 3'd2;
   localparam logic [CODE_W-1:0] OP_HIGH_B   = 3'd3;
   localparam logic [CODE_W-1:0] OP_LOW_A    = 3'd4;
   localparam logic [CODE_W-1:0] OP_LOW_B    = 3'd5;
   localparam logic [CODE_W-1:0] OP_LOW_C    = 3'd6;
   localparam logic [CODE_W-1:0] OP_UNRANKED = 3'd7;
   localparam logic [CODE_W-1:0] OP_NULL     = 3'd0;
   localparam logic [CODE_W-1:0] OP_ONE      = 3'd1;

   // commands the block ignores
   localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_C = 3'd7;

   typedef struct {
      logic [CMD_W-1:0]    cmd;
      logic [HANDLE_W-1:0] handle;
      logic                neg;
      logic [CODE_W-1:0]   opc;
   } token_item_type;

   typedef struct {
      logic [KIND_W-1:0]   kind;
      logic [HANDLE_W-1:0] handle;
      logic                neg;
      logic [CODE_W-1:0]   op;
      logic                err;
      logic                is_last;
   } postfix_item_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;  // number_handle[15:0], number_negative[16], operator_code[19:17]
   logic [2:0]  req_tuser;  // command[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;  // out_handle[15:0], out_negative[16], out_operator[19:17], error[20]
   logic [1:0]  rsp_tuser;  // out_kind[1:0]
   logic        rsp_tlast;

   // token stimulus and expected postfix output
   token_item_type   pending_tokens[$];
   postfix_item_type postfix_expected[$];
   token_item_type   next_token;
   token_item_type   seen_token;
   int               total_tokens;
   int               accepted_items;
   int               mismatch_count;
   int               cycle_count;

   // predictor state
   logic [CODE_W-1:0] op_stack [STACK_DEPTH];
   int                stack_used;
   bit                error_sticky;

   // handshake pacing
   logic req_taken;
   logic calm;
   logic holding;
   int   gap_left;
   int   items_until_gap;
   int   stall_left;
   int   cycles_until_stall;
   int   hold_left;
   bit   hold_done;

   infix_to_postfix_converter_unit #(
      .STACK_DEPTH(STACK_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // clock generation
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // precedence value of a stacked or incoming code
   function automatic logic [1:0] binding_level(logic [CODE_W-1:0] code);
      case (code)
         OP_HIGH_A, OP_HIGH_B:         return itp_pkg::PRIO_HIGH;
         OP_LOW_A, OP_LOW_B, OP_LOW_C: return itp_pkg::PRIO_LOW;
         default:                      return itp_pkg::PRIO_NONE;
      endcase
   endfunction

   function automatic postfix_item_type emitted(logic [KIND_W-1:0] kind,
                                                logic [HANDLE_W-1:0] handle,
                                                logic neg, logic [CODE_W-1:0] op);
      return '{kind: kind, handle: handle, neg: neg, op: op, err: 1'b0, is_last: 1'b0};
   endfunction

   // shunting-yard step for one accepted token
   task automatic predict_postfix(token_item_type tok);
      postfix_item_type  staged[$];
      logic [CODE_W-1:0] code;
      logic [CODE_W-1:0] top;
      logic [1:0]        level;
      bit                found;
      bit                clear_after;
      clear_after = 1'b0;
      case (tok.cmd)
         itp_pkg::CMD_NUMBER: begin
            staged.push_back(emitted(itp_pkg::KIND_NUMBER, tok.handle, tok.neg, '0));
         end
         itp_pkg::CMD_OPEN, itp_pkg::CMD_OPERATOR: begin
            code = (tok.cmd == itp_pkg::CMD_OPEN) ? itp_pkg::CODE_PAREN : tok.opc;
            if (tok.cmd == itp_pkg::CMD_OPEN || tok.opc >= itp_pkg::CODE_OP_MIN) begin
               level = binding_level(code);
               // pop entries that bind no stronger, stop at a parenthesis
               while (stack_used != 0 && op_stack[stack_used-1] != itp_pkg::CODE_PAREN &&
                      level >= binding_level(op_stack[stack_used-1])) begin
                  staged.push_back(emitted(itp_pkg::KIND_OPERATOR, '0, 1'b0,
                                           op_stack[stack_used-1]));
                  stack_used--;
               end
               if (stack_used >= STACK_DEPTH) begin
                  error_sticky = 1'b1;
               end else begin
                  op_stack[stack_used] = code;
                  stack_used++;
               end
            end
         end
         itp_pkg::CMD_CLOSE: begin
            found = 1'b0;
            while (stack_used != 0 && !found) begin
               top = op_stack[stack_used-1];
               stack_used--;
               if (top == itp_pkg::CODE_PAREN) begin
                  found = 1'b1;
               end else begin
                  staged.push_back(emitted(itp_pkg::KIND_OPERATOR, '0, 1'b0, top));
               end
            end
            if (!found) begin
               error_sticky = 1'b1;
            end
         end
         itp_pkg::CMD_END: begin
            // flush from the top, leftover parentheses included
            while (stack_used != 0) begin
               top = op_stack[stack_used-1];
               stack_used--;
               if (top == itp_pkg::CODE_PAREN) begin
                  staged.push_back(emitted(itp_pkg::KIND_PAREN, '0, 1'b0, '0));
               end else begin
                  staged.push_back(emitted(itp_pkg::KIND_OPERATOR, '0, 1'b0, top));
               end
            end
            staged.push_back(emitted(itp_pkg::KIND_END, '0, 1'b0, '0));
            clear_after = 1'b1;
         end
         default: begin
         end
      endcase
      for (int k = 0; k < staged.size(); k++) begin
         staged[k].err     = error_sticky;
         staged[k].is_last = (k == staged.size() - 1);
         postfix_expected.push_back(staged[k]);
      end
      if (clear_after) begin
         stack_used   = 0;
         error_sticky = 1'b0;
      end
   endtask

   task automatic report_mismatch(string msg);
      $display("MISMATCH @%0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   // compare one delivered item with the oldest expectation
   task automatic check_postfix(logic [1:0] kind, logic [23:0] data, logic is_last);
      postfix_item_type want;
      if (postfix_expected.size() == 0) begin
         report_mismatch($sformatf("unexpected item kind %0d data %h", kind, data));
         return;
      end
      want = postfix_expected.pop_front();
      if (kind !== want.kind)
         report_mismatch($sformatf("out_kind %0d, want %0d", kind, want.kind));
      if (data[15:0] !== want.handle)
         report_mismatch($sformatf("out_handle %h, want %h", data[15:0], want.handle));
      if (data[16] !== want.neg)
         report_mismatch($sformatf("out_negative %b, want %b", data[16], want.neg));
      if (data[19:17] !== want.op)
         report_mismatch($sformatf("out_operator %0d, want %0d", data[19:17], want.op));
      if (data[20] !== want.err)
         report_mismatch($sformatf("error %b, want %b", data[20], want.err));
      if (is_last !== want.is_last)
         report_mismatch($sformatf("last %b, want %b", is_last, want.is_last));
   endtask

   // stimulus building
   function automatic logic [CODE_W-1:0] any_code();
      return CODE_W'($urandom_range(0, 7));
   endfunction

   task automatic add_token(logic [CMD_W-1:0] cmd, logic [CODE_W-1:0] opc);
      token_item_type t;
      t.cmd    = cmd;
      t.handle = HANDLE_W'($urandom_range(0, 65535));
      t.neg    = 1'($urandom_range(0, 1));
      t.opc    = opc;
      pending_tokens.push_back(t);
   endtask

   task automatic add_number_token(logic [HANDLE_W-1:0] handle, logic neg);
      add_token(itp_pkg::CMD_NUMBER, any_code());
      pending_tokens[pending_tokens.size()-1].handle = handle;
      pending_tokens[pending_tokens.size()-1].neg    = neg;
   endtask

   // well-formed infix expression with random nesting
   task automatic add_expression(int nest);
      int terms;
      terms = $urandom_range(1, 4);
      for (int i = 0; i < terms; i++) begin
         if (i > 0)
            add_token(itp_pkg::CMD_OPERATOR,
                      ($urandom_range(0, 9) == 0) ? OP_UNRANKED :
                      CODE_W'($urandom_range(OP_HIGH_A, OP_LOW_C)));
         if (nest < 6 && $urandom_range(0, 2) == 0) begin
            add_token(itp_pkg::CMD_OPEN, any_code());
            add_expression(nest + 1);
            add_token(itp_pkg::CMD_CLOSE, any_code());
         end else begin
            add_token(itp_pkg::CMD_NUMBER, any_code());
         end
      end
   endtask

   // parens with optional operators that grow the stack up to or past its depth
   task automatic add_overflow_run();
      int n;
      n = $urandom_range(30, 40);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 2) == 0)
            add_token(itp_pkg::CMD_NUMBER, any_code());
         add_token(itp_pkg::CMD_OPEN, any_code());
         if ($urandom_range(0, 1) == 1)
            add_token(itp_pkg::CMD_OPERATOR, CODE_W'($urandom_range(OP_LOW_A, OP_LOW_C)));
      end
      add_token(itp_pkg::CMD_END, any_code());
   endtask

   task automatic build_stimulus();
      int shape;
      bit first;
      // directed: field extremes, every operator, ignored codes, errors
      add_number_token('0, 1'b0);
      add_number_token('1, 1'b1);
      add_token(itp_pkg::CMD_OPERATOR, OP_HIGH_A);
      add_token(itp_pkg::CMD_NUMBER, any_code());
      add_token(itp_pkg::CMD_OPERATOR, OP_LOW_A);
      add_token(itp_pkg::CMD_OPERATOR, OP_HIGH_B);
      add_token(itp_pkg::CMD_OPERATOR, OP_LOW_B);
      add_token(itp_pkg::CMD_OPERATOR, OP_LOW_C);
      add_token(itp_pkg::CMD_OPERATOR, OP_UNRANKED);
      add_token(itp_pkg::CMD_OPERATOR, OP_NULL);
      add_token(itp_pkg::CMD_OPERATOR, OP_ONE);
      add_token(itp_pkg::CMD_OPEN, any_code());
      add_token(CMD_SPARE_A, any_code());
      add_token(CMD_SPARE_B, any_code());
      add_token(CMD_SPARE_C, any_code());
      add_token(itp_pkg::CMD_CLOSE, any_code());
      add_token(itp_pkg::CMD_CLOSE, any_code());
      add_token(itp_pkg::CMD_END, any_code());
      add_token(itp_pkg::CMD_END, any_code());
      add_token(itp_pkg::CMD_OPEN, any_code());
      add_token(itp_pkg::CMD_OPEN, any_code());
      add_token(itp_pkg::CMD_NUMBER, any_code());
      add_token(itp_pkg::CMD_CLOSE, any_code());
      add_token(itp_pkg::CMD_END, any_code());
      // random: mostly well-formed expressions, some noise and broken ones
      first = 1'b1;
      while (pending_tokens.size() < TOTAL_TOKENS) begin
         shape = first ? 9 : $urandom_range(0, 9);
         first = 1'b0;
         if (shape <= 6) begin
            add_expression(0);
            add_token(itp_pkg::CMD_END, any_code());
         end else if (shape == 7) begin
            repeat ($urandom_range(1, 6))
               add_token(CMD_W'($urandom_range(0, 7)), any_code());
            if ($urandom_range(0, 1) == 1)
               add_token(itp_pkg::CMD_END, any_code());
         end else if (shape == 8) begin
            add_token(itp_pkg::CMD_OPEN, any_code());
            add_expression(1);
            repeat ($urandom_range(0, 2))
               add_token(itp_pkg::CMD_CLOSE, any_code());
            add_token(itp_pkg::CMD_END, any_code());
         end else begin
            add_overflow_run();
         end
      end
   endtask

   // sample handshakes, predict and check
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            seen_token.cmd    = req_tuser;
            seen_token.handle = req_tdata[15:0];
            seen_token.neg    = req_tdata[16];
            seen_token.opc    = req_tdata[19:17];
            predict_postfix(seen_token);
            accepted_items <= accepted_items + 1;
         end
         if (rsp_tvalid && rsp_tready)
            check_postfix(rsp_tuser, rsp_tdata, rsp_tlast);
      end
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // token driver with random gaps
   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_taken)) begin
         if (pending_tokens.size() != 0 && gap_left == 0 &&
             (calm || holding || items_until_gap != 0)) begin
            next_token = pending_tokens.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= next_token.cmd;
            req_tdata  <= {4'd0, next_token.opc, next_token.neg, next_token.handle};
            if (items_until_gap != 0)
               items_until_gap--;
            calm <= (pending_tokens.size() < CALM_TOKENS);
         end else if (pending_tokens.size() != 0 && gap_left == 0) begin
            req_tvalid      <= 1'b0;
            gap_left        = $urandom_range(0, 16);
            items_until_gap = $urandom_range(0, 24);
         end else begin
            req_tvalid <= 1'b0;
            if (gap_left != 0)
               gap_left--;
         end
      end
   end

   // result receiver with random stalls and one long hold-off
   always @(negedge clock) begin
      if (!reset) begin
         if (!hold_done && accepted_items >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!calm && cycles_until_stall == 0) begin
            stall_left         = $urandom_range(0, 16);
            cycles_until_stall = $urandom_range(0, 30);
            rsp_tready <= 1'b0;
         end else begin
            if (cycles_until_stall != 0)
               cycles_until_stall--;
            rsp_tready <= 1'b1;
         end
         holding <= (hold_left != 0);
      end
   end

   // reset, run and final verdict
   initial begin
      reset              = 1'b1;
      req_tvalid         = 1'b0;
      req_tdata          = '0;
      req_tuser          = '0;
      rsp_tready         = 1'b0;
      req_taken          = 1'b0;
      calm               = 1'b0;
      holding            = 1'b0;
      gap_left           = 0;
      items_until_gap    = 0;
      stall_left         = 0;
      cycles_until_stall = 0;
      hold_left          = 0;
      hold_done          = 1'b0;
      accepted_items     = 0;
      mismatch_count     = 0;
      cycle_count        = 0;
      stack_used         = 0;
      error_sticky       = 1'b0;
      build_stimulus();
      total_tokens = pending_tokens.size();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (accepted_items < total_tokens)
         @(negedge clock);
      while (postfix_expected.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (postfix_expected.size() != 0)
         report_mismatch($sformatf("%0d items never arrived", postfix_expected.size()));
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
